// ===== rtl/jfs_pkg.sv =====
// shared types and constants for the jpeg frame splitter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package jfs_pkg;

    localparam logic [7:0]  MARK_PREFIX     = 8'hFF;
    localparam logic [7:0]  MARK_SOI        = 8'hD8;
    localparam logic [7:0]  MARK_EOI        = 8'hD9;
    localparam logic [7:0]  MARK_COMMENT    = 8'hFE;
    localparam logic [7:0]  STAMP_FLAG      = 8'h01;
    localparam logic [31:0] NS_PER_HUNDREDTH = 32'd10000000;

    // one result item as it sits in the output queue
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [31:0] seconds;
        logic [31:0] nanoseconds;
    } result_t;

    // results produced by one input byte: 0, 1 or 2 of them
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

// ===== rtl/jfs_decode.sv =====
// marker parser and timestamp capture for the jpeg frame splitter
// depends on jfs_pkg
`timescale 1ns / 1ps

module jfs_decode (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  logic [7:0]     data,
    output jfs_pkg::push_t push
);
    import jfs_pkg::*;

    typedef enum logic [2:0] {
        PH_SEARCH     = 3'd0,
        PH_SEARCH_FF  = 3'd1,
        PH_IMAGE      = 3'd2,
        PH_IMAGE_FF   = 3'd3,
        PH_HEADER     = 3'd4,
        PH_SECONDS    = 3'd5,
        PH_HUNDREDTHS = 3'd6
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  count_reg, count_next;
    logic [31:0] seconds_reg, seconds_next;
    logic [7:0]  hundredths_reg, hundredths_next;
    logic [31:0] stamp_ns;
    result_t     plain_byte;
    result_t     eoi_byte;
    result_t     prefix_byte;
    result_t     soi_byte;

    assign stamp_ns = 32'(32'(hundredths_reg) * NS_PER_HUNDREDTH);

    always_comb
    begin
        plain_byte  = '{data: data, last: 1'b0, seconds: '0, nanoseconds: '0};
        eoi_byte    = '{data: data, last: 1'b1, seconds: seconds_reg,
                        nanoseconds: stamp_ns};
        prefix_byte = '{data: MARK_PREFIX, last: 1'b0, seconds: '0, nanoseconds: '0};
        soi_byte    = '{data: MARK_SOI, last: 1'b0, seconds: '0, nanoseconds: '0};
    end

    always_comb
    begin
        phase_next      = phase_reg;
        count_next      = count_reg;
        seconds_next    = seconds_reg;
        hundredths_next = hundredths_reg;
        push.count      = 2'd1;
        push.first      = plain_byte;
        push.second     = soi_byte;
        unique case (phase_reg)
            PH_SEARCH_FF:
            begin
                if (data == MARK_SOI)
                begin
                    push.count = 2'd2;
                    push.first = prefix_byte;
                    phase_next = PH_IMAGE;
                end
                else
                begin
                    push.count = 2'd0;
                    phase_next = PH_SEARCH;
                end
            end
            PH_IMAGE:
            begin
                if (data == MARK_PREFIX)
                    phase_next = PH_IMAGE_FF;
            end
            PH_IMAGE_FF:
            begin
                if (data == MARK_EOI)
                begin
                    push.first      = eoi_byte;
                    seconds_next    = '0;
                    hundredths_next = '0;
                    count_next      = '0;
                    phase_next      = PH_SEARCH;
                end
                else if (data == MARK_COMMENT)
                begin
                    count_next = '0;
                    phase_next = PH_HEADER;
                end
                else
                    phase_next = PH_IMAGE;
            end
            PH_HEADER:
            begin
                if (count_reg == 2'd3)
                begin
                    count_next = '0;
                    phase_next = (data == STAMP_FLAG) ? PH_SECONDS : PH_IMAGE;
                end
                else
                    count_next = count_reg + 2'd1;
            end
            PH_SECONDS:
            begin
                // big-endian: shift in from the bottom
                seconds_next = {seconds_reg[23:0], data};
                if (count_reg == 2'd3)
                begin
                    count_next = '0;
                    phase_next = PH_HUNDREDTHS;
                end
                else
                    count_next = count_reg + 2'd1;
            end
            PH_HUNDREDTHS:
            begin
                hundredths_next = data;
                phase_next      = PH_IMAGE;
            end
            default:
            begin
                push.count = 2'd0;
                phase_next = (data == MARK_PREFIX) ? PH_SEARCH_FF : PH_SEARCH;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SEARCH;
            count_reg      <= '0;
            seconds_reg    <= '0;
            hundredths_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            count_reg      <= count_next;
            seconds_reg    <= seconds_next;
            hundredths_reg <= hundredths_next;
        end
    end

    // a double push is always the start marker pair
    assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> push.first.data == MARK_PREFIX &&
                               push.second.data == MARK_SOI)
        else $error("double push is not FF D8");

    // the end marker leaves the timestamp cleared and searching again
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && push.count == 2'd1 && push.first.last |=>
            seconds_reg == '0 && hundredths_reg == '0 && phase_reg == PH_SEARCH)
        else $error("timestamp not cleared after end marker");

    // results outside the end marker carry no stamp
    assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 && !push.first.last |->
            push.first.seconds == '0 && push.first.nanoseconds == '0)
        else $error("stamp on a non-last result");

    // searching phases emit nothing but the start pair
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SEARCH || phase_reg == PH_SEARCH_FF) |->
            push.count != 2'd1)
        else $error("single result while searching");

endmodule

// ===== rtl/jfs_queue.sv =====
// small result queue taking up to two items per cycle, one out per cycle
// depends on jfs_pkg
`timescale 1ns / 1ps

module jfs_queue #(
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_en,
    input  jfs_pkg::push_t   push,
    input  logic             pop,
    output logic             has_room,
    output logic             not_empty,
    output jfs_pkg::result_t head
);
    import jfs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    result_t        entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  fill_reg, fill_next;
    logic [PW-1:0]  wr_ptr_plus1;
    logic [1:0]     push_count;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PW'(DEPTH - 1))
            r = '0;
        else
            r = p + PW'(1);
        return r;
    endfunction

    assign push_count   = push_en ? push.count : 2'd0;
    assign wr_ptr_plus1 = wrap_inc(wr_ptr_reg);
    assign has_room     = fill_reg <= CW'(DEPTH - 2);
    assign not_empty    = fill_reg != '0;
    assign head         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        case (push_count)
            2'd1:    wr_ptr_next = wr_ptr_plus1;
            2'd2:    wr_ptr_next = wrap_inc(wr_ptr_plus1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        fill_next   = fill_reg + CW'(push_count) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            entry_reg[wr_ptr_reg] <= push.first;
        if (push_count == 2'd2)
            entry_reg[wr_ptr_plus1] <= push.second;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEPTH))
        else $error("queue fill above depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        push_count != 2'd0 |-> has_room)
        else $error("push into a queue without room for two");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

endmodule

// ===== rtl/jpeg_frame_splitter_with_timestamp.sv =====
// top level of the motion-jpeg frame splitter with image timestamp
// depends on jfs_pkg, jfs_decode, jfs_queue
`timescale 1ns / 1ps

// an accepted byte is registered in the input register, parsed from there,
// and its results are written into the result queue and shown at its head
// throughput: one byte accepted per cycle while the queue has room; FF D8
// yields two result items, queued and drained one per cycle on result_ready
// reset: asynchronous active low; parser returns to searching with a zero
// timestamp and the input register and result queue come up empty
module jpeg_frame_splitter_with_timestamp #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // byte stream in
    input  logic        data_valid,
    output logic        data_ready,
    input  logic [7:0]  data_in,
    // image bytes out
    output logic        result_valid,
    input  logic        result_ready,
    output logic [7:0]  data_out,
    output logic        last,
    output logic [31:0] stamp_seconds,
    output logic [31:0] stamp_nanoseconds
);
    import jfs_pkg::*;

    // input register: one byte waiting to be parsed
    logic       stage_valid_reg, stage_valid_next;
    logic [7:0] stage_data_reg;

    logic    has_room;
    logic    advance;
    logic    accept;
    logic    pop;
    push_t   push;
    result_t head;

    // the parser only moves when the queue can take a start-marker pair,
    // so the results of one byte are always queued together
    assign advance    = stage_valid_reg && has_room;
    assign data_ready = !stage_valid_reg || has_room;
    assign accept     = data_valid && data_ready;
    assign pop        = result_valid && result_ready;

    always_comb
    begin
        if (accept)
            stage_valid_next = 1'b1;
        else if (advance)
            stage_valid_next = 1'b0;
        else
            stage_valid_next = stage_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
            stage_data_reg <= data_in;
    end

    // marker parsing and timestamp capture
    jfs_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .data  (stage_data_reg),
        .push  (push)
    );

    // result queue decouples the two-result case from the output handshake
    jfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (advance),
        .push      (push),
        .pop       (pop),
        .has_room  (has_room),
        .not_empty (result_valid),
        .head      (head)
    );

    assign data_out          = head.data;
    assign last              = head.last;
    assign stamp_seconds     = head.seconds;
    assign stamp_nanoseconds = head.nanoseconds;

    // a stalled input byte is only held while the queue lacks room for two items
    assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !data_ready |-> !has_room)
        else $error("input held while queue has room");

    // an accepted byte always lands in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> stage_valid_reg)
        else $error("accepted byte lost");

    // the input register empties whenever the parser moves and nothing new arrives
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && !accept |=> !stage_valid_reg)
        else $error("parsed byte not retired");

endmodule
